@@ rtl/min_tracking_stack_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the minimum-tracking stack
// Both macros take a label, clock, active-low reset, antecedent, consequent.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/mts_pkg.sv @@
// ---------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the minimum-tracking stack.
// ---------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);   // holds 0 to STACK_DEPTH
  localparam int VAL_W       = 32;
  localparam int DIFF_W      = 33;

  // action codes
  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_POP_EMPTY = 2'd1;
  localparam logic [1:0] STAT_PUSH_FULL = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  typedef struct packed {
    logic        [1:0]       action;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] top_value;
    logic signed [VAL_W-1:0] min_val;
    logic        [CNT_W-1:0] depth;
    logic                    is_empty;
    logic        [1:0]       status;
  } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/min_tracking_stack.sv @@
// Flow: an accepted beat moves the block to ST_BUSY, which loads the output register
// once the output is not stalled. in_stall is high in ST_BUSY, so no new beat is taken
// until then; a pop takes the new top difference from the store's registered read data.
// Reset: synchronous, active low; clears depth, minimum and handshake state.
// The difference store is not cleared; only entries below the depth are ever read.
// ---------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed values that reports its minimum, using difference encoding.
// ---------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mts_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mts_pkg::out_beat_t      out_data
);

  mts_pkg::state_t state_r, state_nxt;

  logic [mts_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic signed [mts_pkg::VAL_W-1:0]  min_r, min_nxt;
  logic [mts_pkg::DIFF_W-1:0]        top_diff_r, top_diff_nxt;
  logic                              pop_pend_r, pop_pend_nxt;
  logic [1:0]                        status_r, status_nxt;
  logic                              out_valid_r, out_valid_nxt;
  mts_pkg::out_beat_t                out_data_r, out_data_nxt;

  logic                              accept;
  logic                              load_out;
  logic                              wr_en;
  logic [mts_pkg::ADDR_W-1:0]        wr_addr;
  logic [mts_pkg::DIFF_W-1:0]        wr_data;
  logic                              rd_en;
  logic [mts_pkg::ADDR_W-1:0]        rd_addr;
  logic [mts_pkg::DIFF_W-1:0]        rd_data;
  logic [mts_pkg::DIFF_W-1:0]        push_diff;
  logic [mts_pkg::DIFF_W-1:0]        diff_eff;
  logic [mts_pkg::CNT_W-1:0]         count_dec;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != mts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // difference against the minimum in force, 33 bits so it never wraps
  assign push_diff = {in_data.value[mts_pkg::VAL_W-1], in_data.value}
                   - {min_r[mts_pkg::VAL_W-1], min_r};
  assign count_dec = count_r - 1'b1;

  // store access
  assign wr_addr = count_r[mts_pkg::ADDR_W-1:0];
  assign rd_addr = count_dec[mts_pkg::ADDR_W-1:0] - 1'b1;

  mts_diff_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // state register and stack state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::ST_IDLE;
      count_r     <= '0;
      min_r       <= '0;
      pop_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      pop_pend_r  <= pop_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_diff_r <= top_diff_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // top difference after a pop comes from the store
  assign diff_eff = pop_pend_r ? rd_data : top_diff_r;
  assign load_out = !out_valid_r || !out_stall;

  // next state, operation and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    top_diff_nxt  = top_diff_r;
    pop_pend_nxt  = pop_pend_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_data       = push_diff;
    rd_en         = 1'b0;

    unique case (state_r)
      mts_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt    = mts_pkg::ST_BUSY;
          status_nxt   = mts_pkg::STAT_OK;
          pop_pend_nxt = 1'b0;
          case (in_data.action)
            mts_pkg::ACT_PUSH: begin
              if (count_r >= mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)) begin
                status_nxt = mts_pkg::STAT_PUSH_FULL;
              end else if (count_r == '0) begin
                // first entry holds zero
                wr_en        = 1'b1;
                wr_data      = '0;
                min_nxt      = in_data.value;
                count_nxt    = mts_pkg::CNT_W'(1);
                top_diff_nxt = '0;
              end else begin
                wr_en        = 1'b1;
                top_diff_nxt = push_diff;
                count_nxt    = count_r + 1'b1;
                if (in_data.value < min_r) begin
                  min_nxt = in_data.value;
                end
              end
            end
            mts_pkg::ACT_POP: begin
              if (count_r == '0) begin
                status_nxt = mts_pkg::STAT_POP_EMPTY;
              end else begin
                count_nxt = count_dec;
                // negative difference: this entry set the minimum
                if (top_diff_r[mts_pkg::DIFF_W-1]) begin
                  min_nxt = min_r - top_diff_r[mts_pkg::VAL_W-1:0];
                end
                if (count_dec == '0) begin
                  min_nxt = '0;
                end else begin
                  rd_en        = 1'b1;
                  pop_pend_nxt = 1'b1;
                end
              end
            end
            default: begin
              // peek and the unused code change nothing
            end
          endcase
        end
      end

      mts_pkg::ST_BUSY: begin
        if (load_out) begin
          state_nxt              = mts_pkg::ST_IDLE;
          top_diff_nxt           = diff_eff;
          pop_pend_nxt           = 1'b0;
          out_valid_nxt          = 1'b1;
          out_data_nxt.depth     = count_r;
          out_data_nxt.is_empty  = (count_r == '0);
          out_data_nxt.status    = status_r;
          if (count_r == '0) begin
            out_data_nxt.top_value = '0;
            out_data_nxt.min_val   = '0;
          end else begin
            out_data_nxt.min_val = min_r;
            if (!diff_eff[mts_pkg::DIFF_W-1] && (diff_eff != '0)) begin
              out_data_nxt.top_value = diff_eff[mts_pkg::VAL_W-1:0] + min_r;
            end else begin
              out_data_nxt.top_value = min_r;
            end
          end
        end
      end

      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mts_diff_ram.sv @@
// ---------------------------------------------------------------------------
// mts_diff_ram
// Difference store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mts_diff_ram (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [mts_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [mts_pkg::DIFF_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [mts_pkg::ADDR_W-1:0] rd_addr,
  output logic      [mts_pkg::DIFF_W-1:0] rd_data
);

  logic [mts_pkg::DIFF_W-1:0] mem [mts_pkg::STACK_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mts_checker.sv @@
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks on the result channel of the minimum-tracking stack.
// ---------------------------------------------------------------------------
`default_nettype none

`include "min_tracking_stack_assert.svh"

module mts_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mts_pkg::out_beat_t out_data
);

  logic depth_zero;
  logic depth_full;
  logic zero_read;
  logic status_fits;

  // views of the result beat
  assign depth_zero  = (out_data.depth == '0);
  assign depth_full  = (out_data.depth == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));
  assign zero_read   = (out_data.top_value == '0) && (out_data.min_val == '0);
  assign status_fits = ((out_data.status != mts_pkg::STAT_POP_EMPTY) || out_data.is_empty)
                    && ((out_data.status != mts_pkg::STAT_PUSH_FULL) || depth_full);

  // empty flag agrees with the depth
  `MTS_ASSERT_IMPLY(a_empty_flag, clk, rst_n, out_valid, out_data.is_empty == depth_zero)

  // an empty stack reads zero for top and minimum
  `MTS_ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && out_data.is_empty, zero_read)

  // an ignored pop only happens on an empty stack; a dropped push only when full
  `MTS_ASSERT_IMPLY(a_status_state, clk, rst_n, out_valid, status_fits)

  // a stalled result beat holds
  `MTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
